>>> hw/rtl/radio_packet_crc_validator_macros.svh
// Assertion shorthands, clocked on clk, disabled during reset.
`ifndef RADIO_PACKET_CRC_VALIDATOR_MACROS_SVH
`define RADIO_PACKET_CRC_VALIDATOR_MACROS_SVH

// Same-cycle implication.
`define PCV_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PCV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/pcv_pkg.sv
`default_nettype none

package pcv_pkg;

    localparam int MAX_PACKET_BYTES_DEF = 64;
    localparam int LEN_W                = 7;
    localparam int MAX_W                = 8;
    localparam int BIND_W               = 24;

    localparam logic [LEN_W-1:0] MIN_PACKET_BYTES = 7'd10;
    localparam logic [15:0]      NIBBLE_STEP      = 16'h1081;
    localparam int               TAIL_FLAG_BIT    = 7;

    typedef enum logic [1:0] {
        REG_PACKET_LENGTH = 2'd0,
        REG_TAIL_FLAG     = 2'd1,
        REG_BIND_ID       = 2'd2,
        REG_RECEIVER      = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic              tail_req;
        logic [BIND_W-1:0] bind_id;
        logic [7:0]        rcv_num;
    } pcv_cfg_t;

    typedef struct packed {
        logic packet_valid;
        logic crc_ok;
        logic header_ok;
        logic tail_ok;
    } pcv_result_t;

    function automatic logic [15:0] nib_entry(input logic [3:0] n);
        logic [15:0] e;
        unique case (n)
            4'h0: e = 16'h0000;
            4'h1: e = 16'h1189;
            4'h2: e = 16'h2312;
            4'h3: e = 16'h329b;
            4'h4: e = 16'h4624;
            4'h5: e = 16'h57ad;
            4'h6: e = 16'h6536;
            4'h7: e = 16'h74bf;
            4'h8: e = 16'h8c48;
            4'h9: e = 16'h9dc1;
            4'ha: e = 16'haf5a;
            4'hb: e = 16'hbed3;
            4'hc: e = 16'hca6c;
            4'hd: e = 16'hdbe5;
            4'he: e = 16'he97e;
            default: e = 16'hf8f7;
        endcase
        return e;
    endfunction

    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0]  idx;
        logic [15:0] step;
        idx  = crc[15:8] ^ b;
        step = 16'(NIBBLE_STEP * {12'd0, idx[7:4]});
        return {crc[7:0], 8'd0} ^ nib_entry(idx[3:0]) ^ step;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/pcv_cfg_regs.sv
`default_nettype none

module pcv_cfg_regs
    import pcv_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
)(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [BIND_W-1:0] cfg_data,
    output pcv_cfg_t               cfg
);

    localparam logic [MAX_W-1:0] MAX_LEN = MAX_W'(MAX_PACKET_BYTES);

    logic [LEN_W-1:0]  length_reg;
    logic              tail_req_reg;
    logic [BIND_W-1:0] bind_id_reg;
    logic [7:0]        rcv_num_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg   <= 7'd32;
            tail_req_reg <= 1'b0;
            bind_id_reg  <= '0;
            rcv_num_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PACKET_LENGTH: length_reg   <= cfg_data[LEN_W-1:0];
                REG_TAIL_FLAG:     tail_req_reg <= cfg_data[0];
                REG_BIND_ID:       bind_id_reg  <= cfg_data;
                REG_RECEIVER:      rcv_num_reg  <= cfg_data[7:0];
                default:           ;
            endcase
        end
    end

    // clamp length into the supported range
    always_comb
    begin
        if (length_reg < MIN_PACKET_BYTES)
            cfg.len = MIN_PACKET_BYTES;
        else if ({{(MAX_W-LEN_W){1'b0}}, length_reg} > MAX_LEN)
            cfg.len = MAX_LEN[LEN_W-1:0];
        else
            cfg.len = length_reg;
        cfg.tail_req = tail_req_reg;
        cfg.bind_id  = bind_id_reg;
        cfg.rcv_num  = rcv_num_reg;
    end

endmodule

`default_nettype wire

>>> hw/rtl/pcv_check.sv
`default_nettype none

`include "radio_packet_crc_validator_macros.svh"

module pcv_check
    import pcv_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] rx_byte,
    input  wire logic       packet_start,
    input  wire pcv_cfg_t   cfg,
    input  wire logic       res_ready,
    output logic            res_valid,
    output pcv_result_t     res
);

    logic             in_valid_reg, in_valid_next;
    logic [7:0]       in_byte_reg;
    logic             in_start_reg;

    logic [LEN_W-1:0] idx_reg, idx_next;
    logic [15:0]      crc_reg, crc_next;
    logic             in_packet_reg, in_packet_next;
    logic             hdr_reg, hdr_next;
    logic             crc_hi_reg, crc_hi_next;
    logic             crc_lo_reg, crc_lo_next;

    logic             active;
    logic             last;
    logic             retire;
    logic [LEN_W-1:0] i;
    logic [15:0]      cur_crc;
    logic             cur_hdr;
    logic             cur_hi;
    logic             cur_lo;
    logic [7:0]       want;
    logic             tail;
    logic             crc_both;

    always_comb
    begin
        active  = in_valid_reg && (in_start_reg || in_packet_reg);
        i       = in_start_reg ? '0 : idx_reg;
        cur_crc = in_start_reg ? '0 : crc_reg;
        cur_hdr = in_start_reg ? 1'b1 : hdr_reg;
        cur_hi  = in_start_reg ? 1'b0 : crc_hi_reg;
        cur_lo  = in_start_reg ? 1'b0 : crc_lo_reg;
        last    = (i >= cfg.len - 7'd1);

        want = 8'd0;
        unique case (i[1:0])
            2'd1:    want = cfg.bind_id[23:16];
            2'd2:    want = cfg.bind_id[15:8];
            default: want = cfg.bind_id[7:0];
        endcase

        hdr_next = cur_hdr;
        if (i == '0)
            hdr_next = hdr_next && (in_byte_reg == {1'b0, cfg.len - 7'd3});
        else if (i <= 7'd3)
            hdr_next = hdr_next && (in_byte_reg == want);
        if (i == 7'd6)
            hdr_next = hdr_next && ((cfg.rcv_num == 8'd0) || (in_byte_reg == 8'd0)
                                    || (in_byte_reg == cfg.rcv_num));

        crc_next = cur_crc;
        if ((i >= 7'd3) && (i <= cfg.len - 7'd5))
            crc_next = crc_update(cur_crc, in_byte_reg);

        crc_hi_next = cur_hi;
        if (i == cfg.len - 7'd4)
            crc_hi_next = (cur_crc[15:8] == in_byte_reg);
        crc_lo_next = cur_lo;
        if (i == cfg.len - 7'd3)
            crc_lo_next = (cur_crc[7:0] == in_byte_reg);

        tail     = !cfg.tail_req || in_byte_reg[TAIL_FLAG_BIT];
        crc_both = crc_hi_next && crc_lo_next;

        res.packet_valid = crc_both && hdr_next && tail;
        res.crc_ok       = crc_both;
        res.header_ok    = hdr_next;
        res.tail_ok      = tail;
        res_valid        = active && last && res_ready;

        retire        = in_valid_reg && (!(active && last) || res_ready);
        in_stall      = in_valid_reg && !retire;
        in_valid_next = (in_valid && !in_stall) ? 1'b1 : (retire ? 1'b0 : in_valid_reg);

        idx_next       = last ? '0 : i + 7'd1;
        in_packet_next = !last;
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_byte_reg  <= rx_byte;
            in_start_reg <= packet_start;
        end
    end

    // packet state: advance only on a retired byte that belongs to a packet
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            crc_reg       <= '0;
            in_packet_reg <= 1'b0;
            hdr_reg       <= 1'b1;
            crc_hi_reg    <= 1'b0;
            crc_lo_reg    <= 1'b0;
        end
        else if (retire && active)
        begin
            idx_reg       <= idx_next;
            crc_reg       <= crc_next;
            in_packet_reg <= in_packet_next;
            hdr_reg       <= hdr_next;
            crc_hi_reg    <= crc_hi_next;
            crc_lo_reg    <= crc_lo_next;
        end
    end

    `PCV_ASSERT_NOW(a_idle_index_zero, !in_packet_reg, idx_reg == '0, "index nonzero outside packet")
    `PCV_ASSERT_NEXT(a_verdict_closes, res_valid, !in_packet_reg, "packet still open after verdict")
    `PCV_ASSERT_NEXT(a_held_item_kept, in_valid_reg && !retire, in_valid_reg, "held item was lost")
    `PCV_ASSERT_NOW(a_verdict_needs_slot, res_valid, retire, "verdict without retiring byte")

endmodule

`default_nettype wire

>>> hw/rtl/pcv_out_reg.sv
`default_nettype none

`include "radio_packet_crc_validator_macros.svh"

module pcv_out_reg
    import pcv_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        res_valid,
    input  wire pcv_result_t res,
    output logic             res_ready,
    output logic             out_valid,
    input  wire logic        out_stall,
    output pcv_result_t      out_res
);

    logic        valid_reg, valid_next;
    pcv_result_t res_reg;

    always_comb
    begin
        res_ready  = !valid_reg || !out_stall;
        valid_next = res_valid ? 1'b1 : (res_ready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
            res_reg <= res;
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    `PCV_ASSERT_NOW(a_load_into_free_slot, res_valid, res_ready, "result loaded over pending one")
    `PCV_ASSERT_NOW(a_verdict_consistent, valid_reg,
        res_reg.packet_valid == (res_reg.crc_ok && res_reg.header_ok && res_reg.tail_ok),
        "verdict disagrees with its checks")
    `PCV_ASSERT_NEXT(a_new_result_shown, res_valid, valid_reg, "loaded result not shown")

endmodule

`default_nettype wire

>>> hw/rtl/radio_packet_crc_validator.sv
`default_nettype none

// Radio packet CRC validator. Takes one received byte per cycle on the input
// channel unless in_stall is high; a byte with packet_start high opens a
// packet at byte 0. The length byte, bound transmitter id and receiver number
// are checked, the 16-bit CRC runs over bytes 3 to L-5 and is compared against
// bytes L-4 and L-3, and on the last byte (index L-1, L = packet_length clamped
// to 10..MAX_PACKET_BYTES) one verdict item is issued. Bytes outside a packet
// are dropped. Throughput is one byte per cycle while not stalled; the CRC
// update is combinational. The verdict follows the input register, then the
// result register. Write configuration only while no packet is in flight.
module radio_packet_crc_validator
    import pcv_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
)(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [BIND_W-1:0] cfg_data,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [7:0]        rx_byte,
    input  wire logic              packet_start,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic                   packet_valid,
    output logic                   crc_ok,
    output logic                   header_ok,
    output logic                   tail_ok
);

    pcv_cfg_t    cfg;
    pcv_result_t res;
    pcv_result_t out_res;
    logic        res_valid;
    logic        res_ready;

    pcv_cfg_regs #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pcv_check u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .packet_start (packet_start),
        .cfg          (cfg),
        .res_ready    (res_ready),
        .res_valid    (res_valid),
        .res          (res)
    );

    pcv_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign packet_valid = out_res.packet_valid;
    assign crc_ok       = out_res.crc_ok;
    assign header_ok    = out_res.header_ok;
    assign tail_ok      = out_res.tail_ok;

endmodule

`default_nettype wire

>>> sim/radio_packet_crc_validator_tb.sv
module radio_packet_crc_validator_tb;
    import pcv_pkg::*;

    localparam int IDLE_LIMIT   = 3000;
    localparam int TARGET_ITEMS = 1300;
    localparam int SETTLE       = 6;

    class verdict_board;
        logic [6:0]   len_reg;
        bit           tail_req;
        logic [23:0]  bound_id;
        logic [7:0]   rcv_num;
        int unsigned  pos;
        logic [15:0]  crc;
        bit           open;
        bit           hdr;
        bit           hi_ok;
        bit           lo_ok;
        pcv_result_t  expected_verdicts[$];
        int           errors;

        function new();
            len_reg  = 7'd32;
            tail_req = 1'b0;
            bound_id = 24'd0;
            rcv_num  = 8'd0;
            pos      = 0;
            crc      = 16'd0;
            open     = 1'b0;
            hdr      = 1'b1;
            hi_ok    = 1'b0;
            lo_ok    = 1'b0;
            errors   = 0;
        endfunction

        function void set_reg(cfg_index_t idx, logic [23:0] v);
            case (idx)
                REG_PACKET_LENGTH: len_reg  = v[6:0];
                REG_TAIL_FLAG:     tail_req = v[0];
                REG_BIND_ID:       bound_id = v;
                REG_RECEIVER:      rcv_num  = v[7:0];
                default: ;
            endcase
        endfunction

        function int unsigned eff_len();
            if (len_reg < 7'd10)
                return 10;
            if (len_reg > 7'd64)
                return 64;
            return len_reg;
        endfunction

        function logic [15:0] nibble_row(logic [3:0] n);
            case (n)
                4'h0: return 16'h0000;
                4'h1: return 16'h1189;
                4'h2: return 16'h2312;
                4'h3: return 16'h329b;
                4'h4: return 16'h4624;
                4'h5: return 16'h57ad;
                4'h6: return 16'h6536;
                4'h7: return 16'h74bf;
                4'h8: return 16'h8c48;
                4'h9: return 16'h9dc1;
                4'ha: return 16'haf5a;
                4'hb: return 16'hbed3;
                4'hc: return 16'hca6c;
                4'hd: return 16'hdbe5;
                4'he: return 16'he97e;
                default: return 16'hf8f7;
            endcase
        endfunction

        function logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
            logic [7:0]  sel;
            logic [15:0] high_part;
            sel = c[15:8] ^ b;
            high_part = 16'h1081 * {12'd0, sel[7:4]};
            return {c[7:0], 8'h00} ^ nibble_row(sel[3:0]) ^ high_part;
        endfunction

        function void note_byte(logic [7:0] b, bit st);
            int unsigned len;
            pcv_result_t v;
            len = eff_len();
            if (st) begin
                pos   = 0;
                crc   = 16'd0;
                open  = 1'b1;
                hdr   = 1'b1;
                hi_ok = 1'b0;
                lo_ok = 1'b0;
            end else if (!open) begin
                return;
            end
            if (pos == 0)
                hdr = hdr && (b == len - 3);
            else if (pos <= 3)
                hdr = hdr && (b == 8'(bound_id >> (8 * (3 - pos))));
            if (pos == 6)
                hdr = hdr && (rcv_num == 8'd0 || b == 8'd0 || b == rcv_num);
            if (pos >= 3 && pos <= len - 5)
                crc = crc_byte(crc, b);
            if (pos == len - 4)
                hi_ok = (crc[15:8] == b);
            if (pos == len - 3)
                lo_ok = (crc[7:0] == b);
            if (pos >= len - 1) begin
                v.crc_ok       = hi_ok && lo_ok;
                v.header_ok    = hdr;
                v.tail_ok      = !tail_req || b[7];
                v.packet_valid = v.crc_ok && v.header_ok && v.tail_ok;
                expected_verdicts.push_back(v);
                open = 1'b0;
                pos  = 0;
            end else begin
                pos = (pos + 1) % 128;
            end
        endfunction

        function void cmp_field(string name, logic e, logic a);
            if (a !== e) begin
                $display("%0t %s mismatch: expected %0b, got %0b", $time, name, e, a);
                errors++;
            end
        endfunction

        function void check_verdict(pcv_result_t got);
            pcv_result_t e;
            if (expected_verdicts.size() == 0) begin
                $display("%0t unexpected verdict: expected none, got %b", $time, got);
                errors++;
                return;
            end
            e = expected_verdicts.pop_front();
            cmp_field("packet_valid", e.packet_valid, got.packet_valid);
            cmp_field("crc_ok", e.crc_ok, got.crc_ok);
            cmp_field("header_ok", e.header_ok, got.header_ok);
            cmp_field("tail_ok", e.tail_ok, got.tail_ok);
        endfunction

        function int pending();
            return expected_verdicts.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    cfg_index_t  cfg_index;
    logic [23:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  rx_byte;
    logic        packet_start;
    logic        out_valid;
    logic        out_stall;
    logic        packet_valid;
    logic        crc_ok;
    logic        header_ok;
    logic        tail_ok;

    verdict_board sb;
    logic [7:0]   frame[$];
    bit           no_gaps;
    int unsigned  n_items;

    radio_packet_crc_validator u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .packet_start (packet_start),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .packet_valid (packet_valid),
        .crc_ok       (crc_ok),
        .header_ok    (header_ok),
        .tail_ok      (tail_ok)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    task automatic push_byte(input logic [7:0] b, input bit st);
        int unsigned g;
        g = no_gaps ? 0 : pick_gap();
        if (g != 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (g - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid     <= 1'b1;
        rx_byte      <= b;
        packet_start <= st;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_byte(b, st);
    endtask

    task automatic send_frame(input int unsigned upto);
        int unsigned i;
        for (i = 0; i < upto; i++)
            push_byte(frame[i], i == 0);
        n_items += upto;
    endtask

    task automatic build_frame(input bit corrupt, input bit scramble);
        int unsigned L;
        int unsigned k;
        int unsigned r;
        logic [15:0] c;
        L = sb.eff_len();
        frame.delete();
        for (k = 0; k < L; k++)
            frame.push_back(8'($urandom_range(0, 255)));
        if (scramble)
            return;
        frame[0] = 8'(L - 3);
        frame[1] = sb.bound_id[23:16];
        frame[2] = sb.bound_id[15:8];
        frame[3] = sb.bound_id[7:0];
        r = $urandom_range(0, 2);
        if (r == 0)
            frame[6] = sb.rcv_num;
        else if (r == 1)
            frame[6] = 8'h00;
        c = 16'd0;
        for (k = 3; k <= L - 5; k++)
            c = sb.crc_byte(c, frame[k]);
        frame[L - 4] = c[15:8];
        frame[L - 3] = c[7:0];
        if ($urandom_range(0, 3) != 0)
            frame[L - 1] = frame[L - 1] | 8'h80;
        if (corrupt)
        begin
            k = $urandom_range(0, L - 1);
            frame[k] = frame[k] ^ 8'(1 << $urandom_range(0, 7));
        end
    endtask

    // hold the sender until every verdict is in, then let the pipeline settle
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [23:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        sb.set_reg(idx, v);
    endtask

    task automatic reconfigure(input logic [6:0] len, input bit tail,
                               input logic [23:0] id, input logic [7:0] rcv);
        drain();
        write_reg(REG_PACKET_LENGTH, {17'd0, len});
        write_reg(REG_TAIL_FLAG, {23'd0, tail});
        write_reg(REG_BIND_ID, id);
        write_reg(REG_RECEIVER, {16'd0, rcv});
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_config();
        int unsigned r;
        logic [6:0]  len;
        logic [23:0] id;
        logic [7:0]  rcv;
        r = $urandom_range(0, 99);
        if (r < 70)
            len = 7'($urandom_range(10, 20));
        else if (r < 80)
            len = 7'($urandom_range(0, 9));
        else if (r < 90)
            len = 7'($urandom_range(21, 64));
        else
            len = 7'($urandom_range(65, 127));
        r = $urandom_range(0, 9);
        id = (r < 2) ? 24'd0 : (r < 4) ? 24'hffffff : 24'($urandom);
        r = $urandom_range(0, 19);
        rcv = (r < 5) ? 8'd0 : (r < 8) ? 8'hff : 8'($urandom_range(1, 254));
        reconfigure(len, 1'($urandom_range(0, 1)), id, rcv);
    endtask

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check_verdict({packet_valid, crc_ok, header_ok, tail_ok});

    initial
    begin
        int unsigned run;
        int unsigned g;
        out_stall = 1'b0;
        forever
        begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 8);
            repeat (run)
            begin
                @(negedge clk);
                out_stall <= 1'b0;
            end
            g = pick_gap();
            repeat (g)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
            end
        end
    end

    initial
    begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle = 0;
            else
                idle++;
        end
        $display("[radio_packet_crc_validator] ERROR");
        $finish;
    end

    initial
    begin
        int unsigned pkts;
        int unsigned r;
        int unsigned k;
        sb           = new();
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = REG_PACKET_LENGTH;
        cfg_data     = 24'd0;
        in_valid     = 1'b0;
        rx_byte      = 8'd0;
        packet_start = 1'b0;
        no_gaps      = 1'b0;
        n_items      = 0;
        pkts         = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // short length clamps up, stray bytes around a packet are dropped
        reconfigure(7'd5, 1'b1, 24'hffffff, 8'hff);
        push_byte(8'h00, 1'b0);
        push_byte(8'hff, 1'b0);
        build_frame(1'b0, 1'b0);
        send_frame(frame.size());
        push_byte(8'ha5, 1'b0);

        // long length clamps down, then shrinks while the packet is open
        reconfigure(7'd127, 1'b0, 24'd0, 8'd0);
        build_frame(1'b0, 1'b0);
        send_frame(12);
        reconfigure(7'd10, 1'b0, 24'd0, 8'd0);
        push_byte(8'($urandom_range(0, 255)), 1'b0);
        n_items++;

        while (n_items < TARGET_ITEMS)
        begin
            if (pkts % 12 == 0)
                random_config();
            if (pkts == 5 || $urandom_range(0, 19) == 0)
                drain();
            no_gaps = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 65)
            begin
                build_frame(1'b0, 1'b0);
                send_frame(frame.size());
            end
            else if (r < 80)
            begin
                build_frame(1'b1, 1'b0);
                send_frame(frame.size());
            end
            else if (r < 88)
            begin
                build_frame(1'b0, 1'b0);
                send_frame($urandom_range(1, frame.size() - 1));
            end
            else if (r < 94)
            begin
                build_frame(1'b0, 1'b1);
                send_frame(frame.size());
            end
            else
            begin
                for (k = $urandom_range(1, 4); k != 0; k--)
                    push_byte(8'($urandom_range(0, 255)), 1'b0);
            end
            pkts++;
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("[radio_packet_crc_validator] OK");
        else
            $display("[radio_packet_crc_validator] ERROR");
        $finish;
    end

endmodule
